// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file ftrm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define FTRM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FTRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ftrm_pkg.sv -----
package ftrm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_US    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 2'd3;

    localparam logic [15:0] DEBOUNCE_US_RST    = 16'd500;
    localparam logic [15:0] WINDOW_MS_RST      = 16'd1000;
    localparam logic [15:0] TIMEOUT_MS_RST     = 16'd2000;
    localparam logic [3:0]  PULSES_PER_REV_RST = 4'd2;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    localparam int          DIV_STEPS = 17;
    localparam int          DIV_CNT_W = 5;

    localparam logic signed [16:0] RPM_MAX  = 17'sd65535;
    localparam logic signed [16:0] RPM_NONE = -17'sd1;
    localparam logic signed [16:0] RPM_ZERO = 17'sd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_PREP,
        S_DIV,
        S_RES,
        S_DONE
    } ftrm_state_t;

    typedef struct packed {
        logic latch_in;
        logic eval;
        logic mul;
        logic prep;
        logic div_step;
        logic load_rpm;
        logic load_out;
    } ftrm_cmd_t;

    typedef struct packed {
        logic need_div;
    } ftrm_stat_t;

endpackage

// ----- src/ftrm_ctrl.sv -----
module ftrm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ftrm_pkg::ftrm_stat_t stat,
    output ftrm_pkg::ftrm_cmd_t  cmd
);
    import ftrm_pkg::*;

    ftrm_state_t            state_reg;
    ftrm_state_t            state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   out_free;
    logic                   div_last;

    assign out_free = !m_valid_reg || m_ready;
    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = stat.need_div ? S_MUL : S_DONE;
            end
            S_MUL:  state_next = S_PREP;
            S_PREP: state_next = S_DIV;
            S_DIV: begin
                if (div_last) begin
                    state_next = S_RES;
                end
            end
            S_RES:  state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            S_EVAL: cmd.eval = 1'b1;
            S_MUL:  cmd.mul  = 1'b1;
            S_PREP: begin
                cmd.prep = 1'b1;
                cnt_next = '0;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            S_RES:  cmd.load_rpm = 1'b1;
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- src/ftrm_datapath.sv -----
module ftrm_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ftrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_cmd,
    input  logic [31:0]                       s_now_us,
    input  logic [31:0]                       s_now_ms,
    output logic signed [16:0]                m_rpm,
    output logic                              m_edge_accepted,
    output logic                              m_window_evaluated,
    input  ftrm_pkg::ftrm_cmd_t               cmd,
    output ftrm_pkg::ftrm_stat_t              stat
);
    import ftrm_pkg::*;

    logic [15:0]        debounce_us_reg;
    logic [15:0]        window_ms_reg;
    logic [15:0]        timeout_ms_reg;
    logic [3:0]         ppr_reg;

    logic               cmd_reg;
    logic [31:0]        now_us_reg;
    logic [31:0]        now_ms_reg;

    logic [31:0]        pulse_total_reg;
    logic [31:0]        last_edge_us_reg;
    logic [31:0]        last_pulse_ms_reg;
    logic [31:0]        total_at_eval_reg;
    logic [31:0]        last_eval_ms_reg;
    logic signed [16:0] rpm_reg;

    logic [31:0]        pulses_reg;
    logic [31:0]        elapsed_reg;
    logic [47:0]        n_reg;
    logic [35:0]        d_reg;
    logic [49:0]        rem_reg;
    logic [52:0]        dv_reg;
    logic [16:0]        quo_reg;

    logic signed [16:0] out_rpm_reg;
    logic               out_acc_reg;
    logic               out_eval_reg;
    logic               accepted_reg;
    logic               evaluated_reg;

    logic [31:0]        diff_us;
    logic [31:0]        elapsed;
    logic [31:0]        pulses;
    logic [31:0]        idle_ms;
    logic               edge_ok;
    logic               win_ok;
    logic               timed_out;
    logic [3:0]         ppr_eff;
    logic [52:0]        rem_sub;
    logic               ge;

    assign diff_us   = now_us_reg - last_edge_us_reg;
    assign elapsed   = now_ms_reg - last_eval_ms_reg;
    assign pulses    = pulse_total_reg - total_at_eval_reg;
    assign idle_ms   = now_ms_reg - last_pulse_ms_reg;
    assign edge_ok   = (cmd_reg == CMD_EDGE) && (diff_us > {16'b0, debounce_us_reg});
    assign win_ok    = (cmd_reg == CMD_TICK) && (elapsed >= {16'b0, window_ms_reg});
    assign timed_out = idle_ms > {16'b0, timeout_ms_reg};
    assign ppr_eff   = (ppr_reg == 4'd0) ? 4'd1 : ppr_reg;

    assign stat.need_div = win_ok && (pulses != 32'd0) && (elapsed != 32'd0);

    assign rem_sub = {3'b0, rem_reg} - dv_reg;
    assign ge      = ({3'b0, rem_reg} >= dv_reg);

    assign m_rpm              = out_rpm_reg;
    assign m_edge_accepted    = out_acc_reg;
    assign m_window_evaluated = out_eval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_us_reg <= DEBOUNCE_US_RST;
            window_ms_reg   <= WINDOW_MS_RST;
            timeout_ms_reg  <= TIMEOUT_MS_RST;
            ppr_reg         <= PULSES_PER_REV_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE_US:    debounce_us_reg <= cfg_wdata;
                REG_WINDOW_MS:      window_ms_reg   <= cfg_wdata;
                REG_TIMEOUT_MS:     timeout_ms_reg  <= cfg_wdata;
                REG_PULSES_PER_REV: ppr_reg         <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_total_reg   <= '0;
            last_edge_us_reg  <= '0;
            last_pulse_ms_reg <= '0;
            total_at_eval_reg <= '0;
            last_eval_ms_reg  <= '0;
            rpm_reg           <= RPM_NONE;
        end else begin
            if (cmd.eval) begin
                if (edge_ok) begin
                    last_edge_us_reg  <= now_us_reg;
                    pulse_total_reg   <= pulse_total_reg + 32'd1;
                    last_pulse_ms_reg <= now_ms_reg;
                end
                if (win_ok) begin
                    total_at_eval_reg <= pulse_total_reg;
                    last_eval_ms_reg  <= now_ms_reg;
                    if (pulses == 32'd0 && timed_out) begin
                        rpm_reg <= RPM_ZERO;
                    end
                end
            end
            if (cmd.load_rpm) begin
                rpm_reg <= quo_reg[16] ? RPM_MAX : {1'b0, quo_reg[15:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg    <= s_cmd;
            now_us_reg <= s_now_us;
            now_ms_reg <= s_now_ms;
        end
        if (cmd.eval) begin
            accepted_reg  <= edge_ok;
            evaluated_reg <= win_ok;
            pulses_reg    <= pulses;
            elapsed_reg   <= elapsed;
        end
        if (cmd.mul) begin
            n_reg <= {16'b0, pulses_reg} * {32'b0, MS_PER_MIN};
            d_reg <= {4'b0, elapsed_reg} * {32'b0, ppr_eff};
        end
        if (cmd.prep) begin
            rem_reg <= {1'b0, n_reg, 1'b0} + {14'b0, d_reg};
            dv_reg  <= {d_reg, 17'b0};
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_sub[49:0];
            end
            quo_reg <= {quo_reg[15:0], ge};
            dv_reg  <= dv_reg >> 1;
        end
        if (cmd.load_out) begin
            out_rpm_reg  <= rpm_reg;
            out_acc_reg  <= accepted_reg;
            out_eval_reg <= evaluated_reg;
        end
    end

endmodule

// ----- src/fan_tach_rpm_meter.sv -----
// Fan tachometer speed meter.
// Input channel (s_valid/s_ready): one word per event, s_cmd low for a falling
// tach edge, high for an evaluation tick, with s_now_us and s_now_ms timestamps.
// Output channel (m_valid/m_ready): exactly one word per input word, carrying
// the speed after that event (m_rpm, -1 until the first measurement) and flags
// telling whether the edge passed debounce or the tick closed a window.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 debounce_us,
// 1 window_ms, 2 timeout_ms, 3 pulses_per_rev) at once; write only while idle.
// After accept, an edge or a tick that needs no division is evaluated and its
// result then loaded into the output register; a tick that computes a new rpm
// goes between the two through a multiply, an operand set-up, a restoring divider
// that resolves one quotient bit per cycle for 17 bits, and a result step.
// Throughput: one word at a time; a new word is taken as soon as the previous
// result sits in the output register.
// Reset restores the register defaults and clears counters and timestamps; rpm
// returns to -1. When the receiver stalls, the finished word holds in the output
// register, the next word may be taken and processed, and the block then waits
// with s_ready low until the output register frees.
module fan_tach_rpm_meter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ftrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [31:0]                       s_now_us,
    input  logic [31:0]                       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [16:0]                m_rpm,
    output logic                              m_edge_accepted,
    output logic                              m_window_evaluated
);
    import ftrm_pkg::*;

    ftrm_cmd_t  cmd;
    ftrm_stat_t stat;

    ftrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ftrm_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_cmd              (s_cmd),
        .s_now_us           (s_now_us),
        .s_now_ms           (s_now_ms),
        .m_rpm              (m_rpm),
        .m_edge_accepted    (m_edge_accepted),
        .m_window_evaluated (m_window_evaluated),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule

// ----- src/ftrm_checker.sv -----
`include "assert_macros.svh"

module ftrm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [16:0] m_rpm,
    input logic               m_edge_accepted,
    input logic               m_window_evaluated
);

    `FTRM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `FTRM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_rpm), "stalled word changed")

    `FTRM_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second word taken while busy")

    `FTRM_ASSERT(a_flags_exclusive, aclk, aresetn, m_valid |-> !(m_edge_accepted && m_window_evaluated), "edge and window flags both set")

    `FTRM_ASSERT(a_rpm_range, aclk, aresetn, m_valid && m_rpm[16] |-> (&m_rpm), "negative rpm other than unmeasured")

endmodule

bind fan_tach_rpm_meter ftrm_checker u_chk (.*);
